>>> design/mfre_pkg.sv
// ----------------------------------------------------------------------------
// mfre_pkg
// Shared widths, opcodes and transform codes of the matrix flip/rotate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfre_pkg;

   localparam int MAX_DIM_DEFAULT     = 128;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int DIM_W      = 8;
   localparam int INDEX_W    = 7;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [KIND_W-1:0] kind_type;

   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_XFORM = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   localparam kind_type KIND_VFLIP   = 3'd1;
   localparam kind_type KIND_HFLIP   = 3'd2;
   localparam kind_type KIND_ROT_CW  = 3'd3;
   localparam kind_type KIND_ROT_CCW = 3'd4;
   localparam kind_type KIND_QUAD_CW = 3'd5;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

endpackage

`default_nettype wire

>>> design/matrix_flip_rotate_engine.sv
// ----------------------------------------------------------------------------
// matrix_flip_rotate_engine
// Matrix store with element load, element read and whole-matrix transforms.
// ----------------------------------------------------------------------------
// load, read and unused op: result in the cycle after start
// transform: sweep over rows*cols elements, drain, result; busy throughout; one
//   copy pass reads the active bank and writes the other, one element a cycle
// results cannot be stalled by the receiver
// reset: dimensions return to 2x2, load pointer clears, store content is undefined
`default_nettype none

module matrix_flip_rotate_engine #(
   parameter int MAX_DIM     = mfre_pkg::MAX_DIM_DEFAULT,
   parameter int VALUE_WIDTH = mfre_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [mfre_pkg::OP_W-1:0]          req_op,
   input  wire  [VALUE_WIDTH-1:0]             req_value,
   input  wire  [mfre_pkg::KIND_W-1:0]        req_transform_kind,
   input  wire  [mfre_pkg::INDEX_W-1:0]       req_row_index,
   input  wire  [mfre_pkg::INDEX_W-1:0]       req_col_index,
   output logic                               rsp_strobe,
   output logic [VALUE_WIDTH-1:0]             rsp_data,
   output logic [mfre_pkg::DIM_W-1:0]         rsp_rows_now,
   output logic [mfre_pkg::DIM_W-1:0]         rsp_cols_now,
   output logic                               rsp_status,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [mfre_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [mfre_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mfre_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import mfre_pkg::*;

   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int LP_W      = $clog2(DEPTH + 1);
   localparam int MEM_DEPTH = 2 * DEPTH;
   localparam int PROD_W    = 2 * DIM_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   function automatic logic [DIM_W-1:0] legal_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W:0] d;
      d = {1'b0, v[DIM_W-1:0]};
      if (d < (DIM_W+1)'(2)) d = (DIM_W+1)'(2);
      if (d > (DIM_W+1)'(MAX_DIM)) d = (DIM_W+1)'(MAX_DIM);
      return {d[DIM_W-1:1], 1'b0};
   endfunction

   // control state
   logic [1:0]        state_ff, state_in;
   logic              act_ff, act_in;
   logic [DIM_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic              wvalid_ff, wvalid_in;
   logic [LP_W-1:0]   lp_ff, lp_in;
   logic [DIM_W-1:0]  row_count_ff, row_count_in, col_count_ff, col_count_in;
   logic [DIM_W-1:0]  cur_rows_ff, cur_rows_in, cur_cols_ff, cur_cols_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_read_ff, rsp_read_in;
   logic              rsp_status_ff, rsp_status_in;

   // payload
   kind_type          kind_ff, kind_in;
   logic [ADDR_W-1:0] wdst_ff, wdst_in;
   logic [DIM_W-1:0]  rsp_rows_ff, rsp_rows_in, rsp_cols_ff, rsp_cols_in;

   // store: two banks, the active one holds the current matrix
   logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
   logic [VALUE_WIDTH-1:0] mem_rdata_ff;
   logic                   mem_we;
   logic [ADDR_W:0]        mem_waddr, mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;

   logic              accept, cfg_write;
   logic [DIM_W-1:0]  n, m, hn, hm, di, dj, stride;
   logic [PROD_W-1:0] dest_sum, read_sum, area;
   logic              read_ok, load_ok, sweep_last;

   assign accept    = start && (state_ff == ST_IDLE);
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign n  = cur_rows_ff;
   assign m  = cur_cols_ff;
   assign hn = n >> 1;
   assign hm = m >> 1;

   assign area     = PROD_W'(n) * PROD_W'(m);
   assign load_ok  = (32'(lp_ff) < 32'(area)) && (32'(lp_ff) < 32'(DEPTH));
   assign read_ok  = ({1'b0, req_row_index} < n) && ({1'b0, req_col_index} < m);
   assign read_sum = PROD_W'({1'b0, req_row_index}) * PROD_W'(m)
                     + PROD_W'(req_col_index);

   assign sweep_last = (i_ff == n - DIM_W'(1)) && (j_ff == m - DIM_W'(1));

   always_comb begin
      di     = i_ff;
      dj     = j_ff;
      stride = m;
      case (kind_ff)
         KIND_VFLIP: begin
            di = n - DIM_W'(1) - i_ff;
         end
         KIND_HFLIP: begin
            dj = m - DIM_W'(1) - j_ff;
         end
         KIND_ROT_CW: begin
            di     = j_ff;
            dj     = n - DIM_W'(1) - i_ff;
            stride = n;
         end
         KIND_ROT_CCW: begin
            di     = m - DIM_W'(1) - j_ff;
            dj     = i_ff;
            stride = n;
         end
         KIND_QUAD_CW: begin
            if (i_ff < hn) begin
               if (j_ff < hm) dj = j_ff + hm;
               else           di = i_ff + hn;
            end else begin
               if (j_ff >= hm) dj = j_ff - hm;
               else            di = i_ff - hn;
            end
         end
         default: begin
            if (i_ff < hn) begin
               if (j_ff < hm) di = i_ff + hn;
               else           dj = j_ff - hm;
            end else begin
               if (j_ff < hm) dj = j_ff + hm;
               else           di = i_ff - hn;
            end
         end
      endcase
   end

   assign dest_sum = PROD_W'(di) * PROD_W'(stride) + PROD_W'(dj);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      src_in        = src_ff;
      wvalid_in     = 1'b0;
      lp_in         = lp_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      cur_rows_in   = cur_rows_ff;
      cur_cols_in   = cur_cols_ff;
      rsp_valid_in  = 1'b0;
      rsp_read_in   = 1'b0;
      rsp_status_in = 1'b0;
      kind_in       = kind_ff;
      wdst_in       = dest_sum[ADDR_W-1:0];
      rsp_rows_in   = cur_rows_ff;
      rsp_cols_in   = cur_cols_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_LOAD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = !load_ok;
                     if (load_ok) lp_in = lp_ff + LP_W'(1);
                  end
                  OP_XFORM: begin
                     state_in = ST_SWEEP;
                     kind_in  = req_transform_kind;
                     i_in     = '0;
                     j_in     = '0;
                     src_in   = '0;
                  end
                  OP_READ: begin
                     rsp_valid_in  = 1'b1;
                     rsp_read_in   = read_ok;
                     rsp_status_in = !read_ok;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            wvalid_in = 1'b1;
            src_in    = src_ff + ADDR_W'(1);
            if (j_ff == m - DIM_W'(1)) begin
               j_in = '0;
               i_in = i_ff + DIM_W'(1);
            end else begin
               j_in = j_ff + DIM_W'(1);
            end
            if (sweep_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in     = ST_IDLE;
            act_in       = !act_ff;
            rsp_valid_in = 1'b1;
            if (kind_ff inside {KIND_ROT_CW, KIND_ROT_CCW}) begin
               cur_rows_in = cur_cols_ff;
               cur_cols_in = cur_rows_ff;
               rsp_rows_in = cur_cols_ff;
               rsp_cols_in = cur_rows_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_write) begin
         lp_in = '0;
         if (csr_paddr[2] == REG_ROW_COUNT) begin
            row_count_in = legal_dim(csr_pwdata);
            cur_rows_in  = legal_dim(csr_pwdata);
         end else begin
            col_count_in = legal_dim(csr_pwdata);
            cur_cols_in  = legal_dim(csr_pwdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         act_ff        <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         src_ff        <= '0;
         wvalid_ff     <= 1'b0;
         lp_ff         <= '0;
         row_count_ff  <= DIM_W'(2);
         col_count_ff  <= DIM_W'(2);
         cur_rows_ff   <= DIM_W'(2);
         cur_cols_ff   <= DIM_W'(2);
         rsp_valid_ff  <= 1'b0;
         rsp_read_ff   <= 1'b0;
         rsp_status_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         act_ff        <= act_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         src_ff        <= src_in;
         wvalid_ff     <= wvalid_in;
         lp_ff         <= lp_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         cur_rows_ff   <= cur_rows_in;
         cur_cols_ff   <= cur_cols_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      wdst_ff     <= wdst_in;
      rsp_rows_ff <= rsp_rows_in;
      rsp_cols_ff <= rsp_cols_in;
   end

   // copy writes go to the idle bank, loads to the active bank
   always_comb begin
      if (wvalid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = {!act_ff, wdst_ff};
         mem_wdata = mem_rdata_ff;
      end else begin
         mem_we    = accept && (req_op == OP_LOAD) && load_ok;
         mem_waddr = {act_ff, lp_ff[ADDR_W-1:0]};
         mem_wdata = req_value;
      end
      if (state_ff == ST_SWEEP) mem_raddr = {act_ff, src_ff};
      else                      mem_raddr = {act_ff, read_sum[ADDR_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_data     = rsp_read_ff ? mem_rdata_ff : '0;
   assign rsp_rows_now = rsp_rows_ff;
   assign rsp_cols_now = rsp_cols_ff;
   assign rsp_status   = rsp_status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ROW_COUNT) ? CSR_DATA_W'(row_count_ff)
                                                      : CSR_DATA_W'(col_count_ff);

endmodule

`default_nettype wire

>>> design/mfre_checker.sv
// ----------------------------------------------------------------------------
// mfre_checker
// Port-level checks of the matrix flip/rotate engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfre_checker #(
   parameter int VALUE_WIDTH = mfre_pkg::VALUE_WIDTH_DEFAULT
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire [mfre_pkg::OP_W-1:0]     req_op,
   input wire                          rsp_strobe,
   input wire [VALUE_WIDTH-1:0]        rsp_data,
   input wire [mfre_pkg::DIM_W-1:0]    rsp_rows_now,
   input wire [mfre_pkg::DIM_W-1:0]    rsp_cols_now,
   input wire                          rsp_status
);
   import mfre_pkg::*;

   // dimensions are always even
   a_even_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rsp_rows_now[0] && !rsp_cols_now[0])
      else $error("odd dimension on result beat");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |-> rsp_data == '0)
      else $error("error result carries data");

   a_short_item: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op != OP_XFORM |=> rsp_strobe && !busy)
      else $error("single-cycle item gave no result beat");

   a_xform_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == OP_XFORM |=> busy && !rsp_strobe)
      else $error("transform did not hold busy");

   a_xform_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("transform ended without a result beat");

endmodule

bind matrix_flip_rotate_engine mfre_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_mfre_checker (.*);

`default_nettype wire
